[design/bud_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bud_pkg;

  // Generator constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
  localparam int unsigned MIX_SHIFT_1 = 30;
  localparam int unsigned MIX_SHIFT_2 = 27;
  localparam int unsigned MIX_SHIFT_3 = 31;

  // Job queue geometry
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Remainder unit: one dividend bit per cycle
  localparam int unsigned MOD_STEPS = 64;
  localparam int unsigned MOD_CNT_W = 6;

  typedef struct packed {
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic        context_ok;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] drawn_value;
    logic [63:0] raw_sample;
    logic [32:0] range_size;
    logic [63:0] ordinal_out;
  } rsp_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic        refused;
    logic [31:0] range_low;
    logic [32:0] bound;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THR,
    ST_GEN,
    ST_MUL,
    ST_MIX,
    ST_CHECK,
    ST_RED,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[design/bud_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bud_front (
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bud_pkg::req_t req,
  input  wire logic          q_full,
  output logic               push,
  output bud_pkg::job_t      job
);
  import bud_pkg::*;

  // Hold the requester while the queue has no room
  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // Classify the request and form the bound
  always_comb begin
    job.refused   = (req.range_low > req.range_high) || !req.context_ok;
    job.range_low = req.range_low;
    job.bound     = {1'b0, req.range_high} - {1'b0, req.range_low} + 33'd1;
  end

endmodule
`default_nettype wire

[design/bud_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module bud_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bud_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output bud_pkg::job_t      head
);
  import bud_pkg::*;

  job_t                 entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Advance pointers and occupancy on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

[design/bud_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
module bud_mod (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [32:0]   divisor,
  output logic               done,
  output logic [32:0]        rem
);
  import bud_pkg::*;

  logic [63:0]          dvd;
  logic [32:0]          dsr;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic [33:0]          trial;

  // Bring down the next dividend bit
  assign trial = {rem, dvd[63]};

  // Control: count the steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring remainder step
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (trial >= {1'b0, dsr}) rem <= 33'(trial - {1'b0, dsr});
      else                      rem <= trial[32:0];
    end
  end

endmodule
`default_nettype wire

[design/bud_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module bud_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_not_empty,
  input  wire bud_pkg::job_t q_head,
  output logic               pop,
  input  wire logic          seed_load,
  input  wire logic [63:0]   seed,
  output logic               idle,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bud_pkg::rsp_t      rsp
);
  import bud_pkg::*;

  state_t       state;
  state_t       state_next;
  logic [63:0]  gen_state;
  logic [63:0]  call_count;
  logic [31:0]  range_low;
  logic [32:0]  bound;
  logic [32:0]  threshold;
  logic [63:0]  x;
  logic [63:0]  acc;
  logic [63:0]  prod;
  logic [1:0]   phase;
  logic         sel_b;
  logic [63:0]  raw;
  logic [31:0]  drawn;
  logic         refused;

  logic         refuse_now;
  logic         mod_start;
  logic [63:0]  mod_dividend;
  logic [32:0]  mod_divisor;
  logic         mod_done;
  logic [32:0]  mod_rem;
  logic         ld_out;
  logic [63:0]  mul_k;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  gen_sum;

  assign refuse_now = q_head.refused || (call_count == '0);
  assign gen_sum    = gen_state + GOLDEN_STEP;
  assign mul_k      = sel_b ? MIX_MUL_B : MIX_MUL_A;

  bud_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (q_not_empty) state_next = refuse_now ? ST_DONE : ST_THR;
      ST_THR:   if (mod_done) state_next = ST_GEN;
      ST_GEN:   state_next = ST_MUL;
      ST_MUL:   if (phase == 2'd3) state_next = ST_MIX;
      ST_MIX:   state_next = sel_b ? ST_CHECK : ST_MUL;
      ST_CHECK: state_next = (raw < {31'd0, threshold}) ? ST_GEN : ST_RED;
      ST_RED:   if (mod_done) state_next = ST_DONE;
      ST_DONE:  if (ld_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop          = 1'b0;
    mod_start    = 1'b0;
    mod_dividend = raw;
    mod_divisor  = bound;
    ld_out       = 1'b0;
    case (state)
      ST_IDLE: begin
        pop          = q_not_empty;
        mod_start    = q_not_empty && !refuse_now;
        mod_dividend = 64'd0 - {31'd0, q_head.bound};
        mod_divisor  = q_head.bound;
      end
      ST_CHECK: begin
        mod_start = !(raw < {31'd0, threshold});
      end
      ST_DONE: begin
        ld_out = !rsp_valid || !rsp_stall;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign idle = (state == ST_IDLE);

  // Select 32-bit partial product operands
  always_comb begin
    case (phase)
      2'd0:    begin mul_a = x[31:0];  mul_b = mul_k[31:0];  end
      2'd1:    begin mul_a = x[63:32]; mul_b = mul_k[31:0];  end
      2'd2:    begin mul_a = x[31:0];  mul_b = mul_k[63:32]; end
      default: begin mul_a = '0;       mul_b = '0;           end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      gen_state  <= '0;
      call_count <= 64'd1;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_load) begin
        gen_state  <= seed;
        call_count <= 64'd1;
      end else begin
        if (state == ST_GEN) gen_state <= gen_sum;
        if (ld_out && !refused) call_count <= call_count + 64'd1;
      end
      if (ld_out)          rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        range_low <= q_head.range_low;
        bound     <= q_head.bound;
        refused   <= refuse_now;
      end
      ST_THR: begin
        if (mod_done) threshold <= mod_rem;
      end
      ST_GEN: begin
        x     <= gen_sum ^ (gen_sum >> MIX_SHIFT_1);
        sel_b <= 1'b0;
        phase <= 2'd0;
      end
      ST_MUL: begin
        prod  <= {32'd0, mul_a} * {32'd0, mul_b};
        phase <= phase + 2'd1;
        case (phase)
          2'd0:    acc <= acc;
          2'd1:    acc <= prod;
          default: acc <= acc + {prod[31:0], 32'd0};
        endcase
      end
      ST_MIX: begin
        if (sel_b) begin
          raw <= acc ^ (acc >> MIX_SHIFT_3);
        end else begin
          x     <= acc ^ (acc >> MIX_SHIFT_2);
          sel_b <= 1'b1;
          phase <= 2'd0;
        end
      end
      ST_RED: begin
        if (mod_done) drawn <= range_low + mod_rem[31:0];
      end
      default: begin
        phase <= phase;
      end
    endcase
    // Load the response register
    if (ld_out) begin
      rsp.accepted    <= !refused;
      rsp.drawn_value <= refused ? 32'd0 : drawn;
      rsp.raw_sample  <= refused ? 64'd0 : raw;
      rsp.range_size  <= refused ? 33'd0 : bound;
      rsp.ordinal_out <= refused ? 64'd0 : call_count;
    end
  end

endmodule
`default_nettype wire

[design/bounded_uniform_splitmix_draw_unit.sv]
// Bounded uniform draw unit.
// Request channel (req_valid/req_stall, req): inclusive range and context flag.
// Response channel (rsp_valid/rsp_stall, rsp): one response per request, in order.
// Seed channel (cfg_valid/cfg_ready, seed): loads the generator state and sets
// the call ordinal to 1; cfg_ready is high only when no request is in flight.
// A front stage classifies requests into a two-entry queue; the back end runs
// one request at a time through a shared one-bit-per-cycle remainder unit and
// a shared 32x32 multiplier.
// A refused request goes straight to its response. An accepted one makes two
// 64-step remainder passes (threshold, then reduction) around D >= 1 generator
// draws. The back end starts a request only once the last is done; the queue
// takes up to two more.
// Reset: generator state 0, ordinal 1, queue and response register empty.
// While rsp_stall is high the response holds and the back end finishes its
// current request, then waits; req_stall rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module bounded_uniform_splitmix_draw_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire bud_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output bud_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [63:0]   seed
);
  import bud_pkg::*;

  logic  push;
  job_t  push_job;
  logic  q_full;
  logic  q_not_empty;
  job_t  q_head;
  logic  pop;
  logic  back_idle;

  bud_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  bud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bud_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .seed_load   (cfg_valid && cfg_ready),
    .seed        (seed),
    .idle        (back_idle),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

  // Take a seed only with nothing in flight
  assign cfg_ready = back_idle && !q_not_empty && !rsp_valid;

endmodule
`default_nettype wire

[design/bud_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module bud_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rsp_valid,
  input  wire logic          rsp_stall,
  input  wire bud_pkg::rsp_t rsp,
  input  wire logic          cfg_ready
);
  import bud_pkg::*;

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Refused responses carry zeros
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.accepted |-> rsp.drawn_value == '0 && rsp.raw_sample == '0
      && rsp.range_size == '0 && rsp.ordinal_out == '0)
    else $error("refused response has nonzero fields");

  // Accepted draws have a nonzero bound and ordinal
  a_accept_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.accepted |-> rsp.range_size != '0 && rsp.ordinal_out != '0)
    else $error("accepted response with zero bound or ordinal");

  // No seed load while a response is pending
  a_cfg_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !cfg_ready)
    else $error("seed port ready with a response pending");

  // Reset empties the response register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind bounded_uniform_splitmix_draw_unit bud_checker u_bud_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

[tb/tb_bounded_uniform_splitmix_draw_unit.sv]
`timescale 1ns / 1ps
module tb_bounded_uniform_splitmix_draw_unit;
  import bud_pkg::*;

  localparam int unsigned NUM_RANDOM   = 1800;
  localparam int unsigned QUIET_TAIL   = 200;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam logic [63:0] WRAP_EDGE    = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] seed;

  bounded_uniform_splitmix_draw_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .seed      (seed)
  );

  // Predictor state
  logic [63:0] mix_state;
  logic [63:0] next_ordinal;

  req_t pending_reqs[$];
  rsp_t expected_draws[$];
  int   mismatches;
  int   idle_cycles;
  bit   quiet;
  int   req_gap;
  int   rsp_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mix_next();
    logic [63:0] z;
    mix_state = mix_state + GOLDEN_STEP;
    z = mix_state;
    z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SHIFT_2)) * MIX_MUL_B;
    return z ^ (z >> MIX_SHIFT_3);
  endfunction

  // Compute the expected draw for one request and advance the predictor
  function automatic rsp_t predict_draw(req_t r);
    rsp_t        d;
    logic [63:0] bound;
    logic [63:0] thresh;
    logic [63:0] raw;
    d = '0;
    if (r.range_low > r.range_high || !r.context_ok || next_ordinal == 64'd0)
      return d;
    bound  = {32'd0, r.range_high} - {32'd0, r.range_low} + 64'd1;
    thresh = (64'd0 - bound) % bound;
    do
      raw = mix_next();
    while (raw < thresh);
    d.accepted    = 1'b1;
    d.drawn_value = r.range_low + 32'(raw % bound);
    d.raw_sample  = raw;
    d.range_size  = bound[32:0];
    d.ordinal_out = next_ordinal;
    next_ordinal  = next_ordinal + 64'd1;
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: present the next request, hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && !req_stall)
        expected_draws.push_back(predict_draw(req));
      if (!(req_valid && req_stall)) begin
        if (req_gap > 0) begin
          req_gap   <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !cfg_valid) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0)
            req_gap <= $urandom_range(1, 10);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_gap   <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("unexpected response", 64'd0, 64'd0);
        end else begin
          rsp_t e;
          e = expected_draws.pop_front();
          if (rsp.accepted != e.accepted)
            report_mismatch("accepted", 64'(rsp.accepted), 64'(e.accepted));
          if (rsp.drawn_value != e.drawn_value)
            report_mismatch("drawn_value", 64'(rsp.drawn_value), 64'(e.drawn_value));
          if (rsp.raw_sample != e.raw_sample)
            report_mismatch("raw_sample", rsp.raw_sample, e.raw_sample);
          if (rsp.range_size != e.range_size)
            report_mismatch("range_size", 64'(rsp.range_size), 64'(e.range_size));
          if (rsp.ordinal_out != e.ordinal_out)
            report_mismatch("ordinal_out", rsp.ordinal_out, e.ordinal_out);
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap   <= rsp_gap - 1;
        rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_gap   <= $urandom_range(0, 9);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t rand_req();
    req_t        r;
    logic [31:0] a;
    logic [31:0] b;
    int          kind;
    kind = $urandom_range(0, 9);
    a = $urandom();
    b = $urandom();
    r.context_ok = ($urandom_range(0, 9) != 0);
    case (kind)
      0: begin
        r.range_low  = a;
        r.range_high = b;
      end
      1: begin
        r.range_low  = a;
        r.range_high = a + $urandom_range(0, 3);
        if (r.range_high < r.range_low) r.range_high = a;
      end
      2: begin
        // ranges just above a power of two
        r.range_low  = 32'd0;
        r.range_high = 32'h8000_0000 + $urandom_range(0, 15);
      end
      default: begin
        r.range_low  = (a < b) ? a : b;
        r.range_high = (a < b) ? b : a;
      end
    endcase
    return r;
  endfunction

  // Drain everything expected, then let the block settle
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_draws.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_seed(logic [63:0] value);
    cfg_valid <= 1'b1;
    seed      <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    mix_state    = value;
    next_ordinal = 64'd1;
  endtask

  function automatic req_t mk(logic [31:0] lo, logic [31:0] hi, logic ok);
    req_t r;
    r.range_low  = lo;
    r.range_high = hi;
    r.context_ok = ok;
    return r;
  endfunction

  initial begin
    int i;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    seed         = '0;
    req          = '0;
    mismatches   = 0;
    quiet        = 1'b0;
    mix_state    = 64'd0;
    next_ordinal = 64'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset seed, extremes, refusals, full range
    pending_reqs.push_back(mk(32'd0, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(32'd0, 32'd0, 1'b1));
    pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(32'd5, 32'd4, 1'b1));
    pending_reqs.push_back(mk(32'hFFFF_FFFF, 32'd0, 1'b1));
    pending_reqs.push_back(mk(32'd10, 32'd20, 1'b0));
    pending_reqs.push_back(mk(32'd0, 32'h8000_0000, 1'b1));
    pending_reqs.push_back(mk(32'd7, 32'd9, 1'b1));
    pending_reqs.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    wait_drained();

    load_seed(WRAP_EDGE);
    pending_reqs.push_back(mk(32'd1, 32'h7FFF_FFFF, 1'b1));
    pending_reqs.push_back(mk(32'd0, 32'hFFFF_FFFF, 1'b1));
    wait_drained();

    // Reload a seed, then send six requests over the range 0 to 99
    load_seed(64'h0123_4567_89AB_CDEF);
    next_ordinal = 64'd1;
    for (i = 0; i < 6; i++)
      pending_reqs.push_back(mk(32'd0, 32'd99, 1'b1));
    wait_drained();

    // Random phases under several seeds
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_seed(64'd0);
        1: load_seed({$urandom(), $urandom()});
        2: load_seed(64'h8000_0000_0000_0000);
        default: load_seed({$urandom(), $urandom()});
      endcase
      if (phase == 3) quiet = 1'b1;
      for (i = 0; i < (phase == 3 ? QUIET_TAIL : (NUM_RANDOM - QUIET_TAIL) / 3); i++)
        pending_reqs.push_back(rand_req());
      wait_drained();
    end

    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bud_pkg.sv
design/bud_front.sv
design/bud_queue.sv
design/bud_mod.sv
design/bud_back.sv
design/bounded_uniform_splitmix_draw_unit.sv
design/bud_checker.sv
tb/tb_bounded_uniform_splitmix_draw_unit.sv
